// File: hdl/spd_pkg.sv
package spd_pkg;

   localparam int MAX_BARS   = 64;
   localparam int ADDR_W     = $clog2(MAX_BARS);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int PRICE_W    = 32;
   localparam int WIN_W      = 5;
   localparam int PER_W      = 7;
   localparam int WSUM_W     = WIN_W + 1;
   localparam int SUM_W      = PRICE_W + WSUM_W;
   localparam int DEN_W      = PRICE_W + WSUM_W;
   localparam int NUM_W      = SUM_W + 10;
   localparam int STR_W      = 7;
   localparam int QBIT_W     = 3;
   localparam int RESULT_CAP = 64;
   localparam int SCALE      = 1000;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [STR_W-1:0] STR_MAX = STR_W'(100);

   localparam logic [1:0] KIND_HIGH = 2'd0;
   localparam logic [1:0] KIND_LOW  = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd2;

   typedef struct packed {
      logic [PRICE_W-1:0] bar_high;
      logic [PRICE_W-1:0] bar_low;
      logic [PRICE_W-1:0] bar_close;
      logic               last_bar;
   } req_type;

   typedef struct packed {
      logic [1:0]         swing_kind;
      logic [PRICE_W-1:0] swing_price;
      logic [ADDR_W-1:0]  bar_position;
      logic [STR_W-1:0]   strength;
      logic               broken;
      logic               last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_SETUP,
      OP_RD_PRICE,
      OP_GET_PRICE,
      OP_TEST_RD,
      OP_TEST_CMP,
      OP_STR_MUL,
      OP_STR_CHK,
      OP_STR_DIV,
      OP_BRK_INIT,
      OP_BRK_RD,
      OP_BRK_CMP,
      OP_EMIT,
      OP_NEXT,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_none;
      logic k_done;
      logic side;
      logic test_fail;
      logic str_short;
      logic div_done;
      logic j_done;
      logic close_beyond;
      logic out_free;
      logic pend_valid;
      logic cap_hit;
      logic kind_low;
      logic idx_last;
   } dp_status_type;

endpackage

// File: hdl/spd_controller.sv
module spd_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   output spd_pkg::dp_cmd_type   cmd,
   input  spd_pkg::dp_status_type status
);
   import spd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_RD_PRICE, S_GET_PRICE, S_TEST_RD, S_TEST_CMP,
      S_STR_MUL, S_STR_CHK, S_STR_DIV, S_BRK_INIT, S_BRK_RD, S_BRK_CMP,
      S_EMIT, S_NEXT, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_last) state_in = S_SETUP;
         end
         S_SETUP: begin
            state_in = status.scan_none ? S_FINISH : S_RD_PRICE;
         end
         S_RD_PRICE:  state_in = S_GET_PRICE;
         S_GET_PRICE: state_in = S_TEST_RD;
         S_TEST_RD: begin
            if (!status.k_done) state_in = S_TEST_CMP;
            else if (status.side) state_in = S_STR_MUL;
         end
         S_TEST_CMP: begin
            state_in = status.test_fail ? S_NEXT : S_TEST_RD;
         end
         S_STR_MUL: state_in = S_STR_CHK;
         S_STR_CHK: begin
            state_in = status.str_short ? S_BRK_INIT : S_STR_DIV;
         end
         S_STR_DIV: begin
            if (status.div_done) state_in = S_BRK_INIT;
         end
         S_BRK_INIT: state_in = S_BRK_RD;
         S_BRK_RD: begin
            state_in = status.j_done ? S_EMIT : S_BRK_CMP;
         end
         S_BRK_CMP: begin
            state_in = status.close_beyond ? S_EMIT : S_BRK_RD;
         end
         S_EMIT: begin
            if (!status.pend_valid || status.out_free)
               state_in = status.cap_hit ? S_FINISH : S_NEXT;
         end
         S_NEXT: begin
            if (status.kind_low && status.idx_last) state_in = S_FINISH;
            else state_in = S_RD_PRICE;
         end
         S_FINISH: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.load = (state_ff == S_IDLE) && req_valid;
      unique case (state_ff)
         S_IDLE:      cmd.op = OP_IDLE;
         S_SETUP:     cmd.op = OP_SETUP;
         S_RD_PRICE:  cmd.op = OP_RD_PRICE;
         S_GET_PRICE: cmd.op = OP_GET_PRICE;
         S_TEST_RD:   cmd.op = OP_TEST_RD;
         S_TEST_CMP:  cmd.op = OP_TEST_CMP;
         S_STR_MUL:   cmd.op = OP_STR_MUL;
         S_STR_CHK:   cmd.op = OP_STR_CHK;
         S_STR_DIV:   cmd.op = OP_STR_DIV;
         S_BRK_INIT:  cmd.op = OP_BRK_INIT;
         S_BRK_RD:    cmd.op = OP_BRK_RD;
         S_BRK_CMP:   cmd.op = OP_BRK_CMP;
         S_EMIT:      cmd.op = OP_EMIT;
         S_NEXT:      cmd.op = OP_NEXT;
         S_FINISH:    cmd.op = OP_FINISH;
         default:     cmd.op = OP_IDLE;
      endcase
   end

endmodule

// File: hdl/spd_datapath.sv
module spd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  spd_pkg::dp_cmd_type             cmd,
   output spd_pkg::dp_status_type          status,
   input  spd_pkg::req_type                req_payload,
   input  logic                            csr_valid,
   input  logic [spd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spd_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output spd_pkg::rsp_type                rsp_payload
);
   import spd_pkg::*;

   logic [PRICE_W-1:0] high_mem  [MAX_BARS];
   logic [PRICE_W-1:0] low_mem   [MAX_BARS];
   logic [PRICE_W-1:0] close_mem [MAX_BARS];

   // Control state (reset).
   logic [WIN_W-1:0]  left_ff, left_in, right_ff, right_in;
   logic [PER_W-1:0]  period_ff, period_in;
   logic [CNT_W-1:0]  bar_count_ff, bar_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              pend_valid_ff, pend_valid_in;

   // Payload state.
   logic [PRICE_W-1:0] rd_high_ff, rd_low_ff, rd_close_ff;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   stop_ff, stop_in, n_ff, n_in, j_ff, j_in, nres_ff, nres_in;
   logic               kind_ff, kind_in, side_ff, side_in, broken_ff, broken_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [WSUM_W-1:0]  k_ff, k_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [STR_W-1:0]   q_ff, q_in;
   logic [QBIT_W-1:0]  b_ff, b_in;
   rsp_type            pend_ff, pend_in, rsp_ff, rsp_in;

   logic [ADDR_W-1:0]  rd_addr;
   logic [PRICE_W-1:0] v, nbr_gap;
   logic               fail, beyond, out_free, push, str_zero, sat;
   logic [WIN_W-1:0]   limit;
   logic [WSUM_W-1:0]  cnt;
   logic [SUM_W+3:0]   sum_x10;
   logic [NUM_W-1:0]   trial;
   logic [CNT_W:0]     n8, need8, nr8, act8, s8, start8;
   logic               scan_none;
   rsp_type            new_res;

   always_comb begin
      v        = kind_ff ? rd_low_ff : rd_high_ff;
      fail     = kind_ff ? (v <= price_ff) : (v >= price_ff);
      nbr_gap  = kind_ff ? (v - price_ff) : (price_ff - v);
      limit    = side_ff ? right_ff : left_ff;
      cnt      = {1'b0, left_ff} + {1'b0, right_ff};
      sum_x10  = {sum_ff, 3'b000} + {1'b0, sum_ff, 1'b0};
      sat      = sum_x10 >= (SUM_W+4)'(den_ff);
      str_zero = (price_ff == '0) || (cnt == '0);
      trial    = NUM_W'(den_ff) << b_ff;
      beyond   = kind_ff ? (rd_close_ff < price_ff) : (rd_close_ff > price_ff);
      out_free = !rsp_valid_ff || rsp_ready;

      // Scan window from the loaded bar count.
      n8     = {1'b0, bar_count_ff};
      need8  = (CNT_W+1)'(left_ff) + (CNT_W+1)'(right_ff) + (CNT_W+1)'(1);
      nr8    = n8 - (CNT_W+1)'(right_ff);
      act8   = ((CNT_W+1)'(period_ff) < nr8) ? (CNT_W+1)'(period_ff) : nr8;
      s8     = n8 - act8;
      start8 = (s8 < (CNT_W+1)'(left_ff)) ? (CNT_W+1)'(left_ff) : s8;
      scan_none = (n8 < need8) || (start8 >= nr8);

      unique case (cmd.op)
         OP_RD_PRICE: rd_addr = idx_ff;
         OP_TEST_RD:  rd_addr = side_ff ? ADDR_W'({1'b0, idx_ff} + CNT_W'(k_ff))
                                        : ADDR_W'({1'b0, idx_ff} - CNT_W'(k_ff));
         OP_BRK_RD:   rd_addr = j_ff[ADDR_W-1:0];
         default:     rd_addr = idx_ff;
      endcase

      new_res.swing_kind   = kind_ff ? KIND_LOW : KIND_HIGH;
      new_res.swing_price  = price_ff;
      new_res.bar_position = idx_ff;
      new_res.strength     = q_ff;
      new_res.broken       = broken_ff;
      new_res.last_result  = 1'b0;
   end

   always_comb begin
      left_in = left_ff;  right_in = right_ff;  period_in = period_ff;
      bar_count_in = bar_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      pend_valid_in = pend_valid_ff;  pend_in = pend_ff;
      idx_in = idx_ff;  stop_in = stop_ff;  n_in = n_ff;  j_in = j_ff;
      nres_in = nres_ff;  kind_in = kind_ff;  side_in = side_ff;
      broken_in = broken_ff;  price_in = price_ff;  k_in = k_ff;
      sum_in = sum_ff;  den_in = den_ff;  num_in = num_ff;  q_in = q_ff;  b_in = b_ff;
      push = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEFT:   left_in   = csr_data[WIN_W-1:0];
            CSR_RIGHT:  right_in  = csr_data[WIN_W-1:0];
            CSR_PERIOD: period_in = csr_data[PER_W-1:0];
            default: ;
         endcase
      end

      case (cmd.op)
         OP_IDLE: begin
            if (cmd.load && bar_count_ff < CNT_W'(MAX_BARS))
               bar_count_in = bar_count_ff + CNT_W'(1);
         end
         OP_SETUP: begin
            idx_in = start8[ADDR_W-1:0];
            stop_in = nr8[CNT_W-1:0];
            n_in = bar_count_ff;
            kind_in = 1'b0;
            nres_in = '0;
            pend_valid_in = 1'b0;
            bar_count_in = '0;
         end
         OP_GET_PRICE: begin
            price_in = v;
            k_in = WSUM_W'(1);
            side_in = 1'b0;
            sum_in = '0;
         end
         OP_TEST_RD: begin
            if (k_ff > WSUM_W'(limit) && !side_ff) begin
               side_in = 1'b1;
               k_in = WSUM_W'(1);
            end
         end
         OP_TEST_CMP: begin
            if (!fail) begin
               sum_in = sum_ff + SUM_W'(nbr_gap);
               k_in = k_ff + WSUM_W'(1);
            end
         end
         OP_STR_MUL: begin
            den_in = DEN_W'(cnt) * DEN_W'(price_ff);
            num_in = NUM_W'(sum_ff) * NUM_W'(SCALE);
         end
         OP_STR_CHK: begin
            q_in = str_zero ? '0 : (sat ? STR_MAX : '0);
            b_in = QBIT_W'(STR_W-1);
         end
         OP_STR_DIV: begin
            if (num_ff >= trial) begin
               num_in = num_ff - trial;
               q_in[b_ff] = 1'b1;
            end
            b_in = b_ff - QBIT_W'(1);
         end
         OP_BRK_INIT: begin
            j_in = {1'b0, idx_ff} + CNT_W'(1);
            broken_in = 1'b0;
         end
         OP_BRK_CMP: begin
            if (beyond) broken_in = 1'b1;
            else j_in = j_ff + CNT_W'(1);
         end
         OP_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  push = 1'b1;
                  rsp_in = pend_ff;
               end
               pend_in = new_res;
               pend_valid_in = 1'b1;
               nres_in = nres_ff + CNT_W'(1);
            end
         end
         OP_NEXT: begin
            kind_in = !kind_ff;
            if (kind_ff) idx_in = idx_ff + ADDR_W'(1);
         end
         OP_FINISH: begin
            if (out_free) begin
               push = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in = pend_ff;
               end else begin
                  rsp_in = '0;
                  rsp_in.swing_kind = KIND_NONE;
               end
               rsp_in.last_result = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase

      if (push) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= WIN_W'(2);
         right_ff      <= WIN_W'(2);
         period_ff     <= PER_W'(50);
         bar_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         left_ff       <= left_in;
         right_ff      <= right_in;
         period_ff     <= period_in;
         bar_count_ff  <= bar_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;  stop_ff <= stop_in;  n_ff <= n_in;  j_ff <= j_in;
      nres_ff <= nres_in;  kind_ff <= kind_in;  side_ff <= side_in;
      broken_ff <= broken_in;  price_ff <= price_in;  k_ff <= k_in;
      sum_ff <= sum_in;  den_ff <= den_in;  num_ff <= num_in;
      q_ff <= q_in;  b_ff <= b_in;  pend_ff <= pend_in;  rsp_ff <= rsp_in;
   end

   // Bar stores: one write port for loading, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.load && bar_count_ff < CNT_W'(MAX_BARS)) begin
         high_mem[bar_count_ff[ADDR_W-1:0]]  <= req_payload.bar_high;
         low_mem[bar_count_ff[ADDR_W-1:0]]   <= req_payload.bar_low;
         close_mem[bar_count_ff[ADDR_W-1:0]] <= req_payload.bar_close;
      end
      rd_high_ff  <= high_mem[rd_addr];
      rd_low_ff   <= low_mem[rd_addr];
      rd_close_ff <= close_mem[rd_addr];
   end

   always_comb begin
      status.scan_none    = scan_none;
      status.k_done       = k_ff > WSUM_W'(limit);
      status.side         = side_ff;
      status.test_fail    = fail;
      status.str_short    = str_zero || sat;
      status.div_done     = (b_ff == '0);
      status.j_done       = (j_ff >= n_ff);
      status.close_beyond = beyond;
      status.out_free     = out_free;
      status.pend_valid   = pend_valid_ff;
      status.cap_hit      = (nres_ff == CNT_W'(RESULT_CAP-1));
      status.kind_low     = kind_ff;
      status.idx_last     = (({1'b0, idx_ff} + CNT_W'(1)) >= stop_ff);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hdl/swing_point_detector_top.sv
// Swing point detector.
// Bars arrive as transactions on the req channel (high, low, close, last_bar) and are
// stored one per cycle, up to 64 bars; later bars are dropped. A bar without last_bar
// produces no result. The transaction that carries last_bar starts a scan of the stored
// series, and req_ready stays low until the scan has handed its last result to the
// output register. Each swing found comes out as one rsp transaction; the final one,
// or a single "none" result, carries last_result.
// The scan is run by one shared compare unit reading the bar stores through a single
// registered read port. For each scanned bar and kind it reads the candidate price,
// then compares the neighbors on the left side and then the right side in turn. A
// swing then gets its strength, from the seven-step divider unless the ratio is zero
// or saturates, then a break test over later closes until one lies beyond its price,
// and is then emitted. Each scan starts with a setup step and ends with a finish step.
// Results pass through a pending register and an output register, so the scan keeps
// running while the receiver stalls until a second result has to wait.
// The csr channel is always ready; writes are expected only between scans.
// Reset clears the bar count and output valid and restores window 2, 2 and period 50.
module swing_point_detector_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  spd_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output spd_pkg::rsp_type                rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import spd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers accept a write in every cycle.
   assign csr_ready = 1'b1;

   spd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last_bar),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   spd_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hdl/spd_checker.sv
module spd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spd_pkg::rsp_type rsp_payload
);
   import spd_pkg::*;

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // While a scan still has results to deliver, no new bar is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_result |-> !req_ready)
      else $error("bar accepted during a scan");

   // A none result always closes its scan.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.swing_kind == KIND_NONE |-> rsp_payload.last_result)
      else $error("none result without last flag");

   // Strength stays within its clamp.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.strength <= STR_MAX)
      else $error("strength out of range");

endmodule

bind swing_point_detector_top spd_checker u_spd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// File: verif/tb_swing_point_detector_top.sv
module tb_swing_point_detector_top;
   import spd_pkg::*;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request channel.
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;

   // Response channel.
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // Register write channel.
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   swing_point_detector_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bars waiting to be offered, and swings the block still owes us.
   req_type pending_bars[$];
   rsp_type expected_swings[$];
   int      fail_count = 0;
   int      bars_queued = 0;

   // Our own copy of the detector: the bar series and the window settings.
   logic [PRICE_W-1:0] high_mem [MAX_BARS];
   logic [PRICE_W-1:0] low_mem  [MAX_BARS];
   logic [PRICE_W-1:0] close_mem[MAX_BARS];
   int unsigned        bar_total  = 0;
   int unsigned        win_left   = 2;
   int unsigned        win_right  = 2;
   int unsigned        period_len = 50;

   // Sender burst control and receiver long-hold handshake between processes.
   int   burst_left = 0;
   int   gap_left   = 0;
   logic hold_go    = 1'b0;
   logic hold_seen  = 1'b0;
   int   hold_left  = 0;
   int   stall_pct  = 0;
   int   stall_tick = 0;

   // Store one bar, and when it closes the series, scan it and queue the swings found.
   task automatic detect_swings(input req_type bar);
      int unsigned n, span, first, stop, pos, k, kind, found, cnt;
      logic [PRICE_W-1:0] p, v;
      longint unsigned dist_sum, denom, ratio;
      logic pivot, brk;
      rsp_type r;
      if (bar_total < MAX_BARS) begin
         high_mem[bar_total]  = bar.bar_high;
         low_mem[bar_total]   = bar.bar_low;
         close_mem[bar_total] = bar.bar_close;
         bar_total++;
      end
      if (!bar.last_bar) return;
      n = bar_total;
      found = 0;
      if (n >= win_left + win_right + 1) begin
         span = n - win_right;
         if (period_len < span) span = period_len;
         first = n - span;
         if (first < win_left) first = win_left;
         stop = n - win_right;
         for (pos = first; pos < stop; pos++) begin
            for (kind = 0; kind < 2; kind++) begin
               if (found >= RESULT_CAP) continue;
               p = kind ? low_mem[pos] : high_mem[pos];
               pivot = 1'b1;
               dist_sum = 0;
               // Neighbors on both sides must lie strictly beyond the candidate.
               for (k = 1; k <= win_left + win_right; k++) begin
                  if (k <= win_left)
                     v = kind ? low_mem[pos-k] : high_mem[pos-k];
                  else
                     v = kind ? low_mem[pos+k-win_left] : high_mem[pos+k-win_left];
                  if (kind ? (v <= p) : (v >= p)) pivot = 1'b0;
                  else dist_sum += kind ? longint'(v - p) : longint'(p - v);
               end
               if (!pivot) continue;
               cnt = win_left + win_right;
               ratio = 0;
               if (p != 0 && cnt != 0) begin
                  denom = longint'(cnt) * longint'(p);
                  ratio = (dist_sum * 1000) / denom;
                  if (ratio > 100) ratio = 100;
               end
               brk = 1'b0;
               for (k = pos + 1; k < n; k++)
                  if (kind ? (close_mem[k] < p) : (close_mem[k] > p)) brk = 1'b1;
               r.swing_kind   = kind ? KIND_LOW : KIND_HIGH;
               r.swing_price  = p;
               r.bar_position = pos[ADDR_W-1:0];
               r.strength     = ratio[STR_W-1:0];
               r.broken       = brk;
               r.last_result  = 1'b0;
               expected_swings = {expected_swings, r};
               found++;
            end
         end
      end
      if (found == 0) begin
         r = '0;
         r.swing_kind = KIND_NONE;
         expected_swings = {expected_swings, r};
      end
      expected_swings[expected_swings.size()-1].last_result = 1'b1;
      bar_total = 0;
   endtask

   // Every bar the block takes goes through the predictor.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         detect_swings(req_payload);
   end

   // Driver: bursts of bars separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bars.size() > 0) begin
            req_payload <= pending_bars.pop_front();
            req_valid   <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: a random stall rate is picked whenever the tick counter wraps, with an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_tick == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct <= 0;
               1: stall_pct <= 25;
               2: stall_pct <= 50;
               default: stall_pct <= 90;
            endcase
         end
         stall_tick <= (stall_tick + 1) % 64;
         rsp_ready  <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Monitor: every transaction on the response side is matched against the oldest swing.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_swings.size() == 0) begin
            $error("unexpected response transaction %p", rsp_payload);
            fail_count++;
         end else begin
            want = expected_swings.pop_front();
            if (rsp_payload.swing_kind !== want.swing_kind) begin
               $error("swing_kind expected %0d actual %0d", want.swing_kind,
                      rsp_payload.swing_kind);
               fail_count++;
            end
            if (rsp_payload.swing_price !== want.swing_price) begin
               $error("swing_price expected %0h actual %0h", want.swing_price,
                      rsp_payload.swing_price);
               fail_count++;
            end
            if (rsp_payload.bar_position !== want.bar_position) begin
               $error("bar_position expected %0d actual %0d", want.bar_position,
                      rsp_payload.bar_position);
               fail_count++;
            end
            if (rsp_payload.strength !== want.strength) begin
               $error("strength expected %0d actual %0d", want.strength,
                      rsp_payload.strength);
               fail_count++;
            end
            if (rsp_payload.broken !== want.broken) begin
               $error("broken expected %0b actual %0b", want.broken, rsp_payload.broken);
               fail_count++;
            end
            if (rsp_payload.last_result !== want.last_result) begin
               $error("last_result expected %0b actual %0b", want.last_result,
                      rsp_payload.last_result);
               fail_count++;
            end
         end
      end
   end

   // Wait until the block has nothing left in flight, then give its scan time to settle.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_bars.size() != 0 || req_valid || expected_swings.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEFT:   win_left   = value & 5'h1f;
         CSR_RIGHT:  win_right  = value & 5'h1f;
         CSR_PERIOD: period_len = value & 7'h7f;
         default: ;
      endcase
   endtask

   task automatic set_windows(input int unsigned l, input int unsigned r, input int unsigned p);
      write_reg(CSR_LEFT, l);
      write_reg(CSR_RIGHT, r);
      write_reg(CSR_PERIOD, p);
      @(posedge clock);
   endtask

   // Queue one bar. Prices wander around a base so that swings actually occur;
   // full-range mode exercises every price bit.
   task automatic queue_bar(input int mode, inout logic [PRICE_W-1:0] base,
                            input logic last);
      req_type b;
      case (mode)
         0: begin
            b.bar_high  = $urandom;
            b.bar_low   = $urandom;
            b.bar_close = $urandom;
         end
         1: begin
            base        = base + $urandom_range(0, 16) - 8;
            b.bar_high  = base + $urandom_range(0, 6);
            b.bar_low   = base - $urandom_range(0, 6);
            b.bar_close = base + $urandom_range(0, 12) - 6;
         end
         default: begin
            b.bar_high  = ($urandom_range(0, 1)) ? '1 : $urandom_range(0, 3);
            b.bar_low   = ($urandom_range(0, 1)) ? '0 : $urandom_range(0, 3);
            b.bar_close = ($urandom_range(0, 1)) ? '1 : '0;
         end
      endcase
      b.last_bar = last;
      pending_bars = {pending_bars, b};
      bars_queued++;
   endtask

   task automatic queue_series(input int len, input int mode);
      logic [PRICE_W-1:0] base;
      base = $urandom;
      for (int i = 0; i < len; i++)
         queue_bar(mode, base, i == len - 1);
   endtask

   initial begin
      req_type b;
      int      series_cnt;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a lone bar, a short series below the window size, and a clean
      // peak and trough at reset windows, with extreme prices and a zero-price low.
      queue_series(1, 1);
      queue_series(3, 1);
      b = '0; b.bar_high = 32'd10; b.bar_low = 32'd5; b.bar_close = 32'd7;
      pending_bars = {pending_bars, b};
      b.bar_high = 32'd20; b.bar_low = 32'd3;
      pending_bars = {pending_bars, b};
      b.bar_high = 32'hffff_ffff; b.bar_low = 32'd0; b.bar_close = 32'hffff_ffff;
      pending_bars = {pending_bars, b};
      b.bar_high = 32'd20; b.bar_low = 32'd3; b.bar_close = 32'd0;
      pending_bars = {pending_bars, b};
      b.bar_high = 32'd10; b.bar_low = 32'd5; b.bar_close = 32'd0; b.last_bar = 1'b1;
      pending_bars = {pending_bars, b};
      bars_queued += 5;
      wait_drained();

      // Both windows zero: every scanned bar is a high and a low, so the result cap hits.
      set_windows(0, 0, 64);
      queue_series(40, 1);
      wait_drained();

      // Widest windows and a period past the store; the series overflows the store.
      set_windows(31, 31, 127);
      queue_series(70, 2);
      wait_drained();

      // Narrowest scan, and a period of zero that scans nothing.
      set_windows(1, 0, 1);
      queue_series(6, 1);
      wait_drained();
      set_windows(1, 1, 0);
      queue_series(5, 1);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering several series.
      set_windows(1, 1, 64);
      hold_go <= ~hold_go;
      for (int i = 0; i < 4; i++) queue_series(12, 1);
      wait_drained();

      // Random phases: mostly short wandering series with random windows.
      while (bars_queued < 480) begin
         set_windows(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4),
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(1, 64));
         series_cnt = $urandom_range(2, 4);
         for (int i = 0; i < series_cnt; i++)
            queue_series(($urandom_range(0, 9) == 0) ? $urandom_range(60, 68)
                                                      : $urandom_range(3, 20),
                         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 1);
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0 && expected_swings.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

endmodule
